// File: rtl/delayed_window_difference_sensor_assert.svh
// assertion macros shared by the rtl of the delayed window difference sensor
// depends on nothing; files that check their own logic include it
`ifndef DELAYED_WINDOW_DIFFERENCE_SENSOR_ASSERT_SVH
`define DELAYED_WINDOW_DIFFERENCE_SENSOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DWS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DWS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dws_pkg.sv
// types and constants of the delayed window difference sensor
// depends on nothing; used by the front end, the back end and the top level
package dws_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_DELAY_LEN    = 3'd0;
  localparam logic [2:0] REG_RECENT_LEN   = 3'd1;
  localparam logic [2:0] REG_PAST_LEN     = 3'd2;
  localparam logic [2:0] REG_RECENT_RECIP = 3'd3;
  localparam logic [2:0] REG_PAST_RECIP   = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int LEN_W      = 8;
  localparam int RECIP_W    = 17;
  localparam int LEVEL_W    = 17;
  localparam int FRAC_W     = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 17'h1FFFF;
  localparam logic [RECIP_W-1:0] RECIP_ONE   = 17'h10000;
  localparam int unsigned        ROUND_HALF  = 32768;

  // queue depths between front, back and result port
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  typedef struct packed {
    logic [LEN_W-1:0]   delay_len;
    logic [LEN_W-1:0]   recent_len;
    logic [LEN_W-1:0]   past_len;
    logic [RECIP_W-1:0] recent_recip;
    logic [RECIP_W-1:0] past_recip;
  } cfg_t;

  // item kind and window check travel with each request
  typedef struct packed {
    logic func;
    logic err;
  } tag_t;

endpackage

// File: rtl/dws_fifo.sv
// small register queue with occupancy count
// depends only on the shared assertion header
`include "delayed_window_difference_sensor_assert.svh"

module dws_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       rd_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] store_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;

  // pointer and count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (wr_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_i && rd_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      store_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = store_q[rptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  `DWS_ASSERT_NOW(a_fifo_no_overflow, clk_i, rst_ni, wr_i && !rd_i,
                  count_q != CntW'(Depth), "fifo written while full")
  `DWS_ASSERT_NOW(a_fifo_no_underflow, clk_i, rst_ni, rd_i,
                  count_q != '0, "fifo read while empty")

endmodule

// File: rtl/dws_front.sv
// front end: takes items, keeps the history ring and fetches the three window taps
// depends on dws_pkg and the shared assertion header
`include "delayed_window_difference_sensor_assert.svh"

module dws_front
  import dws_pkg::*;
#(
  parameter int HistDepth   = 256,
  parameter int SampleWidth = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic                           func_i,
  input  logic signed [SampleWidth-1:0]  sample_i,
  input  cfg_t                           cfg_i,
  input  logic [$clog2(MID_DEPTH+1)-1:0] mid_count_i,
  output logic                           mid_wr_o,
  output tag_t                           mid_tag_o,
  output logic signed [SampleWidth-1:0]  a_o,
  output logic signed [SampleWidth-1:0]  b_o,
  output logic signed [SampleWidth-1:0]  c_o
);

  localparam int AW  = $clog2(HistDepth);
  localparam int FW  = $clog2(HistDepth + 1);
  localparam int KW  = LEN_W + 2;
  localparam int CW  = (FW > KW) ? FW : KW;
  localparam int MCW = $clog2(MID_DEPTH + 1);

  logic                          accept;
  logic                          err;
  logic [MCW-1:0]                pending;
  logic [FW-1:0]                 fill_nxt;
  logic [KW-1:0]                 back_ofs [3];
  logic [AW-1:0]                 rd_addr [3];
  logic                          is_base [3];
  logic                          is_fwd [3];
  logic [SampleWidth-1:0]        rd_data [3];
  logic [SampleWidth-1:0]        tap [3];

  logic [AW-1:0]                 wp_q, wp_d;
  logic [FW-1:0]                 fill_q, fill_d;
  logic signed [SampleWidth-1:0] base_q, base_d;

  logic                          f_vld_q;
  tag_t                          f_tag_q;
  logic [2:0]                    f_base_q;
  logic [2:0]                    f_fwd_q;
  logic [SampleWidth-1:0]        f_smp_q;
  logic [SampleWidth-1:0]        f_base_lvl_q;

  // credit against the middle queue, counting the request in the read stage
  assign pending = mid_count_i + MCW'(f_vld_q);
  assign full    = (pending >= MCW'(MID_DEPTH));
  assign accept  = push && !full;

  // window taps as distances back from the newest sample
  assign back_ofs[0] = KW'(cfg_i.delay_len);
  assign back_ofs[1] = back_ofs[0] + KW'(cfg_i.recent_len);
  assign back_ofs[2] = back_ofs[1] + KW'(cfg_i.past_len);
  assign err         = (CW'(back_ofs[2]) > CW'(HistDepth - 1));

  assign fill_nxt = (fill_q < FW'(HistDepth)) ? fill_q + 1'b1 : fill_q;

  // ring pointer, fill count and base level
  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    base_d = base_q;
    if (accept) begin
      if (func_i) begin
        wp_d   = '0;
        fill_d = '0;
        base_d = sample_i;
      end else begin
        wp_d   = (wp_q == AW'(HistDepth - 1)) ? '0 : wp_q + 1'b1;
        fill_d = fill_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      base_q <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      base_q <= base_d;
    end
  end

  // one ring copy per tap, all written with the same sample
  for (genvar g = 0; g < 3; g++) begin : g_tap
    logic [CW:0]            slot_raw;
    logic [CW:0]            slot_wrap;
    logic [SampleWidth-1:0] ring [HistDepth];
    logic [SampleWidth-1:0] rd_q;

    assign slot_raw   = {1'b0, CW'(wp_q)} - {1'b0, CW'(back_ofs[g])};
    assign slot_wrap  = slot_raw[CW] ? slot_raw + (CW+1)'(HistDepth) : slot_raw;
    assign rd_addr[g] = err ? '0 : slot_wrap[AW-1:0];
    assign is_base[g] = (CW'(back_ofs[g]) >= CW'(fill_nxt));
    assign is_fwd[g]  = (back_ofs[g] == '0);

    always_ff @(posedge clk_i) begin
      if (accept && !func_i) begin
        ring[wp_q] <= sample_i;
      end
      if (accept) begin
        rd_q <= ring[rd_addr[g]];
      end
    end

    assign rd_data[g] = rd_q;
  end

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= accept;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_tag_q      <= '{func: func_i, err: err};
      f_base_q     <= {is_base[2], is_base[1], is_base[0]};
      f_fwd_q      <= {is_fwd[2], is_fwd[1], is_fwd[0]};
      f_smp_q      <= sample_i;
      f_base_lvl_q <= base_q;
    end
  end

  // unwritten slots read as base, the tap at distance zero is the new sample
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (f_base_q[i]) begin
        tap[i] = f_base_lvl_q;
      end else if (f_fwd_q[i]) begin
        tap[i] = f_smp_q;
      end else begin
        tap[i] = rd_data[i];
      end
    end
  end

  assign mid_wr_o  = f_vld_q;
  assign mid_tag_o = f_tag_q;
  assign a_o       = tap[0];
  assign b_o       = tap[1];
  assign c_o       = tap[2];

  `DWS_ASSERT_NEXT(a_prime_restarts_ring, clk_i, rst_ni, accept && func_i, (wp_q == '0) && (fill_q == '0), "prime did not restart the ring")

endmodule

// File: rtl/dws_back.sv
// back end: running window sums, scaling by the reciprocals and rounding
// depends on dws_pkg and the shared assertion header
`include "delayed_window_difference_sensor_assert.svh"

module dws_back
  import dws_pkg::*;
#(
  parameter int SampleWidth = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cfg_t                           cfg_i,
  input  logic                           mid_empty_i,
  input  tag_t                           mid_tag_i,
  input  logic signed [SampleWidth-1:0]  a_i,
  input  logic signed [SampleWidth-1:0]  b_i,
  input  logic signed [SampleWidth-1:0]  c_i,
  output logic                           mid_rd_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count_i,
  output logic                           out_wr_o,
  output logic [LEVEL_W-1:0]             on_level_o,
  output logic [LEVEL_W-1:0]             off_level_o,
  output logic                           config_error_o
);

  localparam int SumW  = SampleWidth + 10;
  localparam int ProdW = SumW + RECIP_W + 1;
  localparam int DiffW = ProdW + 1;
  localparam int LvlW  = DiffW - FRAC_W;
  localparam int OCW   = $clog2(OUT_DEPTH + 1);

  logic                    take;
  logic [OCW-1:0]          used;

  logic signed [SumW-1:0]  recent_q, recent_d;
  logic signed [SumW-1:0]  past_q, past_d;
  logic signed [SumW-1:0]  a_ext, b_ext, c_ext;
  logic signed [ProdW-1:0] rs_mul, rr_mul, ps_mul, pr_mul;
  logic signed [ProdW-1:0] prod_r_q, prod_p_q;
  logic signed [DiffW-1:0] diff_q;
  logic [DiffW-1:0]        rnd;
  logic [LvlW-1:0]         lvl;
  logic [LEVEL_W-1:0]      sat;
  logic                    zero_out;

  logic                    s0_vld_q, s1_vld_q, s2_vld_q;
  tag_t                    s0_tag_q, s1_tag_q, s2_tag_q;

  // take a request only while the result queue has room for everything in flight
  assign used     = out_count_i + OCW'(s0_vld_q) + OCW'(s1_vld_q) + OCW'(s2_vld_q);
  assign take     = !mid_empty_i && (used < OCW'(OUT_DEPTH));
  assign mid_rd_o = take;

  // running sums: what enters one window leaves the other
  assign a_ext = SumW'(a_i);
  assign b_ext = SumW'(b_i);
  assign c_ext = SumW'(c_i);

  always_comb begin
    recent_d = recent_q;
    past_d   = past_q;
    if (take) begin
      if (mid_tag_i.func) begin
        recent_d = '0;
        past_d   = '0;
      end else if (!mid_tag_i.err) begin
        recent_d = recent_q + a_ext - b_ext;
        past_d   = past_q + b_ext - c_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      past_q   <= '0;
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      recent_q <= recent_d;
      past_q   <= past_d;
      s0_vld_q <= take;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
    end
  end

  // scale both sums by their reciprocals
  assign rs_mul = ProdW'(recent_q);
  assign rr_mul = $signed(ProdW'({1'b0, cfg_i.recent_recip}));
  assign ps_mul = ProdW'(past_q);
  assign pr_mul = $signed(ProdW'({1'b0, cfg_i.past_recip}));

  always_ff @(posedge clk_i) begin
    if (take) begin
      s0_tag_q <= mid_tag_i;
    end
    if (s0_vld_q) begin
      prod_r_q <= rs_mul * rr_mul;
      prod_p_q <= ps_mul * pr_mul;
      s1_tag_q <= s0_tag_q;
    end
    if (s1_vld_q) begin
      diff_q   <= DiffW'(prod_r_q) - DiffW'(prod_p_q);
      s2_tag_q <= s1_tag_q;
    end
  end

  // magnitude rounded half away from zero, then saturated
  always_comb begin
    if (diff_q[DiffW-1]) begin
      rnd = DiffW'(ROUND_HALF) - diff_q;
    end else begin
      rnd = diff_q + DiffW'(ROUND_HALF);
    end
  end

  assign lvl      = rnd[DiffW-1:FRAC_W];
  assign sat      = (lvl > LvlW'(LEVEL_MAX)) ? LEVEL_MAX : lvl[LEVEL_W-1:0];
  assign zero_out = s2_tag_q.func || s2_tag_q.err;

  assign out_wr_o       = s2_vld_q;
  assign on_level_o     = (zero_out || diff_q[DiffW-1]) ? '0 : sat;
  assign off_level_o    = (zero_out || !diff_q[DiffW-1]) ? '0 : sat;
  assign config_error_o = s2_tag_q.err;

  `DWS_ASSERT_NOW(a_out_credit, clk_i, rst_ni, 1'b1, used <= OCW'(OUT_DEPTH), "result queue overcommitted")

endmodule

// File: rtl/delayed_window_difference_sensor.sv
// Delayed window difference sensor, top level.
//
// Input channel: push / full. An item (func_i, sample_i) is taken at a clock
// edge with push high and full low. func_i low appends sample_i (signed Q8.8)
// to the history; func_i high primes: both sums clear and the history reads
// as sample_i until it is refilled.
// Result channel: empty / pop. The oldest result (on_level_o, off_level_o,
// config_error_o) is on the ports while empty is low and leaves on pop.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Write only while no request is in flight.
// Throughput: one item per cycle while full is low. A taken item passes the
// ring read and tap select, the middle queue, sum update, multiply, subtract.
// Each tap has its own copy of the history ring, so the three reads of an
// item happen in the same cycle as its write.
// When pop stalls, up to 8 results wait in the result queue; the back end
// then stops draining the 4-entry middle queue and full rises once that fills.
// Reset: registers go to delay 0, windows 1, reciprocals 1.0; sums, pointer,
// fill count and base level clear; no clearing pass, taken items start at once.

module delayed_window_difference_sensor
  import dws_pkg::*;
#(
  parameter int HIST_DEPTH   = 256,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          func_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [LEVEL_W-1:0]            on_level_o,
  output logic [LEVEL_W-1:0]            off_level_o,
  output logic                          config_error_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int TagW = $bits(tag_t);
  localparam int MidW = TagW + 3 * SAMPLE_WIDTH;
  localparam int OutW = 2 * LEVEL_W + 1;
  localparam int MCW  = $clog2(MID_DEPTH + 1);
  localparam int OCW  = $clog2(OUT_DEPTH + 1);

  cfg_t                           cfg_q;

  logic                           mid_wr;
  tag_t                           front_tag;
  logic signed [SAMPLE_WIDTH-1:0] front_a, front_b, front_c;
  logic [MidW-1:0]                mid_wdata, mid_rdata;
  logic                           mid_rd;
  logic                           mid_empty;
  logic [MCW-1:0]                 mid_count;
  tag_t                           back_tag;
  logic signed [SAMPLE_WIDTH-1:0] back_a, back_b, back_c;

  logic                           out_wr;
  logic [LEVEL_W-1:0]             back_on, back_off;
  logic                           back_err;
  logic [OutW-1:0]                out_wdata, out_rdata;
  logic [OCW-1:0]                 out_count;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_len    <= '0;
      cfg_q.recent_len   <= LEN_W'(1);
      cfg_q.past_len     <= LEN_W'(1);
      cfg_q.recent_recip <= RECIP_ONE;
      cfg_q.past_recip   <= RECIP_ONE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DELAY_LEN:    cfg_q.delay_len    <= cfg_data_i[LEN_W-1:0];
        REG_RECENT_LEN:   cfg_q.recent_len   <= cfg_data_i[LEN_W-1:0];
        REG_PAST_LEN:     cfg_q.past_len     <= cfg_data_i[LEN_W-1:0];
        REG_RECENT_RECIP: cfg_q.recent_recip <= cfg_data_i[RECIP_W-1:0];
        REG_PAST_RECIP:   cfg_q.past_recip   <= cfg_data_i[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: history ring and tap fetch
  dws_front #(
    .HistDepth  (HIST_DEPTH),
    .SampleWidth(SAMPLE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .func_i     (func_i),
    .sample_i   (sample_i),
    .cfg_i      (cfg_q),
    .mid_count_i(mid_count),
    .mid_wr_o   (mid_wr),
    .mid_tag_o  (front_tag),
    .a_o        (front_a),
    .b_o        (front_b),
    .c_o        (front_c)
  );

  // middle queue between front and back
  assign mid_wdata = {front_tag, front_a, front_b, front_c};

  dws_fifo #(
    .Width(MidW),
    .Depth(MID_DEPTH)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (mid_wr),
    .wdata_i(mid_wdata),
    .rd_i   (mid_rd),
    .rdata_o(mid_rdata),
    .empty_o(mid_empty),
    .count_o(mid_count)
  );

  assign {back_tag, back_a, back_b, back_c} = mid_rdata;

  // back end: sums, scaling and rounding
  dws_back #(
    .SampleWidth(SAMPLE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .mid_empty_i   (mid_empty),
    .mid_tag_i     (back_tag),
    .a_i           (back_a),
    .b_i           (back_b),
    .c_i           (back_c),
    .mid_rd_o      (mid_rd),
    .out_count_i   (out_count),
    .out_wr_o      (out_wr),
    .on_level_o    (back_on),
    .off_level_o   (back_off),
    .config_error_o(back_err)
  );

  // result queue
  assign out_wdata = {back_on, back_off, back_err};

  dws_fifo #(
    .Width(OutW),
    .Depth(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (out_wr),
    .wdata_i(out_wdata),
    .rd_i   (pop && !empty),
    .rdata_o(out_rdata),
    .empty_o(empty),
    .count_o(out_count)
  );

  assign {on_level_o, off_level_o, config_error_o} = out_rdata;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// testbench for delayed_window_difference_sensor: sample and prime requests under many window
// settings, each result checked against a predictor of the two running means; uses dws_pkg
module testbench;
  import dws_pkg::*;

  localparam int HIST_LEN    = 256;
  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = SAMPLE_W + 10;
  localparam int SETTLE      = 12;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
    bit                         drain_first;
  } sensor_req_t;

  typedef struct {
    logic [LEVEL_W-1:0] on_lvl;
    logic [LEVEL_W-1:0] off_lvl;
    logic               cfg_err;
  } level_t;

  // block ports, all inputs known from the start
  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       push        = 1'b0;
  logic                       func_i      = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_i    = '0;
  logic                       pop         = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = REG_DELAY_LEN;
  logic [CFG_DATA_W-1:0]      cfg_data_i  = '0;
  logic                       full;
  logic                       empty;
  logic [LEVEL_W-1:0]         on_level_o;
  logic [LEVEL_W-1:0]         off_level_o;
  logic                       config_error_o;
  logic                       cfg_ready_o;

  // predictor state
  cfg_t regs_now = '{delay_len: 8'd0, recent_len: 8'd1, past_len: 8'd1,
                     recent_recip: RECIP_ONE, past_recip: RECIP_ONE};
  logic signed [SAMPLE_W-1:0] ring [HIST_LEN];
  logic [7:0]                 wr_ptr     = '0;
  logic [8:0]                 filled     = '0;
  logic signed [SAMPLE_W-1:0] base_lvl   = '0;
  logic signed [SUM_W-1:0]    recent_acc = '0;
  logic signed [SUM_W-1:0]    past_acc   = '0;

  // request and result bookkeeping
  sensor_req_t samples_pending [$];
  level_t      levels_due [$];
  sensor_req_t in_flight;
  level_t      due_lvl;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int hold_token    = 0;
  int hold_ack      = 0;
  int hold_len      = 0;
  int hold_left     = 0;
  int walk_lvl      = 0;
  int cycle_count   = 0;
  int mismatches    = 0;
  int items_taken   = 0;
  int primes_taken  = 0;
  int results_seen  = 0;
  int err_results   = 0;
  int sat_results   = 0;
  int settings_run  = 0;

  int idle_send [4] = '{0, 75, 0, 22};
  int idle_pop  [4] = '{0, 0, 75, 22};

  // directed requests under reset settings: field extremes, primes, unwritten history
  int dir_lvl   [20] = '{32767, -32768, 0, 1, -1, 21845, -21846, 32767, 32767, -32768,
                         -32768, 32767, -32768, 0, -32768, 32767, 32767, 1, 0, -1};
  bit dir_prime [20] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                         0, 1, 0, 0, 1, 0, 0, 0, 1, 0};

  delayed_window_difference_sensor #(
    .HIST_DEPTH  (HIST_LEN),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .func_i        (func_i),
    .sample_i      (sample_i),
    .empty         (empty),
    .pop           (pop),
    .on_level_o    (on_level_o),
    .off_level_o   (off_level_o),
    .config_error_o(config_error_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // sample k back from the newest; slots beyond the fill count read as the base level
  function automatic logic signed [SAMPLE_W-1:0] tap_back(input int unsigned k);
    if (k >= filled) return base_lvl;
    return ring[(int'(wr_ptr) + 2 * HIST_LEN - 1 - k) % HIST_LEN];
  endfunction

  // q.16 magnitude to q8.8, round half up, saturate
  function automatic logic [LEVEL_W-1:0] to_level(input longint mag);
    longint r;
    r = (mag + longint'(ROUND_HALF)) >>> FRAC_W;
    return (r > longint'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(r);
  endfunction

  // advance the window sums by one request and form the on/off levels
  function automatic level_t sensor_step(input sensor_req_t req);
    level_t                     res;
    int unsigned                reach;
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic signed [SAMPLE_W-1:0] c;
    longint                     diff;
    reach = int'(regs_now.delay_len) + int'(regs_now.recent_len) + int'(regs_now.past_len);
    res.on_lvl  = '0;
    res.off_lvl = '0;
    res.cfg_err = (reach > HIST_LEN - 1);
    if (req.func) begin
      base_lvl   = req.sample;
      recent_acc = '0;
      past_acc   = '0;
      wr_ptr     = '0;
      filled     = '0;
    end else begin
      ring[wr_ptr] = req.sample;
      wr_ptr = wr_ptr + 1'b1;
      if (filled < HIST_LEN) filled = filled + 1'b1;
      // bad windows: sample kept, sums frozen, levels zero
      if (!res.cfg_err) begin
        a = tap_back(int'(regs_now.delay_len));
        b = tap_back(int'(regs_now.delay_len) + int'(regs_now.recent_len));
        c = tap_back(reach);
        recent_acc = recent_acc + a - b;
        past_acc   = past_acc + b - c;
        diff = longint'(recent_acc) * longint'(regs_now.recent_recip)
             - longint'(past_acc) * longint'(regs_now.past_recip);
        if (diff > 0) res.on_lvl = to_level(diff);
        else if (diff < 0) res.off_lvl = to_level(-diff);
      end
    end
    return res;
  endfunction

  // request driver: holds a request until taken, else offers the next or idles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        levels_due.push_back(sensor_step(in_flight));
        items_taken++;
        if (in_flight.func) primes_taken++;
      end
      if (!push || !full) begin
        if (samples_pending.size() > 0 && $urandom_range(99) >= send_idle_pct &&
            (!samples_pending[0].drain_first || levels_due.size() == 0)) begin
          in_flight = samples_pending.pop_front();
          push      <= 1'b1;
          func_i    <= in_flight.func;
          sample_i  <= in_flight.sample;
        end else begin
          push     <= 1'b0;
          func_i   <= 1'($urandom);
          sample_i <= SAMPLE_W'($urandom);
        end
      end
    end
  end

  // result monitor and pop control
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (levels_due.size() == 0) begin
          $display("%0t: result with nothing expected: on %0d off %0d err %0d",
                   $time, on_level_o, off_level_o, config_error_o);
          mismatches++;
        end else begin
          due_lvl = levels_due.pop_front();
          results_seen++;
          if (on_level_o !== due_lvl.on_lvl) begin
            $display("%0t: on_level expected %0d, got %0d", $time, due_lvl.on_lvl, on_level_o);
            mismatches++;
          end
          if (off_level_o !== due_lvl.off_lvl) begin
            $display("%0t: off_level expected %0d, got %0d",
                     $time, due_lvl.off_lvl, off_level_o);
            mismatches++;
          end
          if (config_error_o !== due_lvl.cfg_err) begin
            $display("%0t: config_error expected %0d, got %0d",
                     $time, due_lvl.cfg_err, config_error_o);
            mismatches++;
          end
          if (due_lvl.cfg_err) err_results++;
          if (due_lvl.on_lvl == LEVEL_MAX || due_lvl.off_lvl == LEVEL_MAX) sat_results++;
        end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_ack != hold_token) begin
        hold_ack  <= hold_token;
        hold_left <= hold_len;
        pop       <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, levels_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic cfg_t settings(input int d, input int r, input int p,
                                    input int rr, input int pr);
    cfg_t c;
    c.delay_len    = LEN_W'(d);
    c.recent_len   = LEN_W'(r);
    c.past_len     = LEN_W'(p);
    c.recent_recip = RECIP_W'(rr);
    c.past_recip   = RECIP_W'(pr);
    return c;
  endfunction

  // length word, sometimes with junk above the register width
  function automatic logic [CFG_DATA_W-1:0] len_word(input logic [LEN_W-1:0] len);
    logic [CFG_DATA_W-LEN_W-1:0] junk;
    junk = ($urandom_range(2) == 0) ? (CFG_DATA_W-LEN_W)'($urandom) : '0;
    return {junk, len};
  endfunction

  // matching reciprocal most of the time, an arbitrary one otherwise
  function automatic logic [RECIP_W-1:0] recip_of(input logic [LEN_W-1:0] len);
    if (len == 0 || $urandom_range(3) == 0) return RECIP_W'($urandom_range(131071));
    return RECIP_W'((65536 + len / 2) / len);
  endfunction

  // wait until no request is pending or in flight, then let the pipeline settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (samples_pending.size() != 0 || push || levels_due.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // write all registers back to back plus one write past the register list
  task automatic load_settings(input cfg_t c);
    logic [CFG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx[0] = REG_DELAY_LEN;    val[0] = len_word(c.delay_len);
    idx[1] = REG_RECENT_LEN;   val[1] = len_word(c.recent_len);
    idx[2] = REG_PAST_LEN;     val[2] = len_word(c.past_len);
    idx[3] = REG_RECENT_RECIP; val[3] = c.recent_recip;
    idx[4] = REG_PAST_RECIP;   val[4] = c.past_recip;
    idx[5] = CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_PAST_RECIP + 1));
    val[5] = CFG_DATA_W'($urandom);
    foreach (idx[i]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i);
      while (!cfg_ready_o);
      case (idx[i])
        REG_DELAY_LEN:    regs_now.delay_len    = val[i][LEN_W-1:0];
        REG_RECENT_LEN:   regs_now.recent_len   = val[i][LEN_W-1:0];
        REG_PAST_LEN:     regs_now.past_len     = val[i][LEN_W-1:0];
        REG_RECENT_RECIP: regs_now.recent_recip = val[i][RECIP_W-1:0];
        REG_PAST_RECIP:   regs_now.past_recip   = val[i][RECIP_W-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // random requests: mostly a slow walk, with steps, rails, noise and rare primes
  task automatic queue_samples(input int n, input bit prime_first);
    sensor_req_t req;
    int          pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      req.drain_first = (i == n / 2);
      req.func = (i == 0 && prime_first) || pick < 2;
      if (pick < 55) begin
        walk_lvl = walk_lvl + int'($urandom_range(512)) - 256;
        if (walk_lvl > 32767) walk_lvl = 32767;
        if (walk_lvl < -32768) walk_lvl = -32768;
      end else if (pick < 75) begin
        walk_lvl = int'($urandom_range(65535)) - 32768;
      end else if (pick < 85) begin
        walk_lvl = $urandom_range(1) ? 32767 : -32768;
      end
      req.sample = (pick < 85) ? SAMPLE_W'(walk_lvl) : SAMPLE_W'($urandom);
      samples_pending.push_back(req);
    end
  endtask

  task automatic run_phase(input cfg_t c, input int n, input int s_idle, input int p_stall,
                           input bit prime_first, input bit long_hold);
    wait_drained();
    load_settings(c);
    @(negedge clk_i);
    send_idle_pct = s_idle;
    pop_stall_pct = p_stall;
    if (long_hold) begin
      hold_len = HOLD_CYCLES;
      hold_token++;
    end
    queue_samples(n, prime_first);
    settings_run++;
  endtask

  // stimulus sequence
  initial begin
    sensor_req_t req;
    int          d;
    int          r;
    int          p;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part under reset settings
    @(negedge clk_i);
    foreach (dir_lvl[i]) begin
      req.func        = dir_prime[i];
      req.sample      = SAMPLE_W'(dir_lvl[i]);
      req.drain_first = 1'b0;
      samples_pending.push_back(req);
    end

    // fixed settings, extremes among them
    run_phase(settings(3, 4, 8, 16384, 8192), 240, 0, 0, 1, 1);
    run_phase(settings(253, 1, 1, 65536, 65536), 200, 75, 0, 1, 0);
    run_phase(settings(0, 254, 1, 258, 65536), 240, 0, 75, 1, 0);
    run_phase(settings(0, 200, 54, 131071, 0), 240, 22, 22, 1, 0);
    // windows reach past the history, then zero windows and zero reciprocals without a prime
    run_phase(settings(200, 50, 10, 65536, 65536), 60, 0, 0, 0, 0);
    run_phase(settings(5, 0, 0, 65536, 65536), 100, 75, 0, 0, 0);
    run_phase(settings(0, 1, 1, 0, 0), 60, 0, 75, 0, 0);

    // random settings
    for (int i = 0; i < 4; i++) begin
      d = $urandom_range(120);
      r = $urandom_range(90);
      p = $urandom_range(84);
      run_phase(settings(d, r, p, recip_of(LEN_W'(r)), recip_of(LEN_W'(p))), 200,
                idle_send[i], idle_pop[i], $urandom_range(1), i == 0);
    end

    wait_drained();
    $display("%0d requests taken (%0d primes) under %0d window settings, %0d results checked",
             items_taken, primes_taken, settings_run + 1, results_seen);
    $display("%0d results with bad window settings, %0d saturated levels",
             err_results, sat_results);
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
